// ----- rtl/tph_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the temperature and humidity compensation core.
// Used by every module of the core; depends on nothing else.

package tph_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_T1  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T2  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_T3  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H1  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H2  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H3  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H45 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_H6  = 4'd7;

    // Internal datapath widths, sized to the value ranges they carry.
    localparam int FINE_W = 22;   // fine temperature
    localparam int T_W    = 17;   // temperature in centidegrees
    localparam int X_W    = 23;   // fine temperature minus offset
    localparam int HUM_W  = 17;   // humidity in percent times 1024

    localparam logic signed [24:0]    T_ROUND      = 25'sd128;
    localparam logic signed [X_W-1:0] FINE_OFFSET  = 23'sd76800;
    localparam logic [31:0]           P_ROUND      = 32'd16384;
    localparam logic signed [20:0]    Q2_BIAS      = 21'sd32768;
    localparam logic signed [22:0]    Q_BIAS       = 23'sd2097152;
    localparam logic [31:0]           Q_ROUND      = 32'd8192;
    localparam logic signed [31:0]    HUM_V_MAX    = 32'sd419430400;
    localparam logic [HUM_W-1:0]      HUM_Q10_MAX  = 17'd102400;

    // Reciprocal multipliers: ceil(2^26 / 100) and ceil(2^13 / 11).
    localparam logic [19:0]           DIV100_RECIP = 20'd671089;
    localparam logic [9:0]            DIV11_RECIP  = 10'd745;
    localparam logic [T_W-1:0]        CENTI_SCALE  = 17'd100;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } cal_t;

endpackage

// ----- rtl/tph_temp_pipe.sv -----
`timescale 1ns / 1ps
// Four-stage temperature pipeline: raw temperature reading to fine temperature.
// Depends on tph_pkg for the calibration struct and widths.

module tph_temp_pipe
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tph_pkg::cal_t                     cal,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic [19:0]                       raw_t,
    input  logic [15:0]                       raw_h,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic signed [tph_pkg::FINE_W-1:0] fine,
    output logic [15:0]                       adc_h
);

    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_in;
    logic [NST:0]   rdy;

    // Stage 0: differences against T1.
    logic signed [17:0] d1_reg, d1_next;
    logic signed [17:0] d2_reg, d2_next;
    // Stage 1: first products.
    logic signed [33:0] m1;
    logic signed [35:0] m2;
    logic signed [20:0] v1_reg, v1_next;
    logic signed [19:0] v2a_reg, v2a_next;
    // Stage 2: T3 product.
    logic signed [35:0] m3;
    logic signed [20:0] v1b_reg;
    logic signed [17:0] v2_reg, v2_next;
    // Stage 3: fine temperature.
    logic signed [tph_pkg::FINE_W-1:0] fine_reg, fine_next;

    logic [15:0] hraw_reg [NST];

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        rdy[NST] = dn_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[NST-2:0], up_valid};

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            vld_next[k] = rdy[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign d1_next  = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    assign d2_next  = $signed({2'b0, raw_t[19:4]}) - $signed({2'b0, cal.t1});

    assign m1       = d1_reg * $signed(cal.t2);
    assign m2       = d2_reg * d2_reg;
    assign v1_next  = m1[31:11];
    assign v2a_next = m2[31:12];

    assign m3       = v2a_reg * $signed(cal.t3);
    assign v2_next  = m3[31:14];

    assign fine_next = v1b_reg + v2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            hraw_reg[0] <= raw_h;
        end
        if (rdy[1])
        begin
            v1_reg      <= v1_next;
            v2a_reg     <= v2a_next;
            hraw_reg[1] <= hraw_reg[0];
        end
        if (rdy[2])
        begin
            v1b_reg     <= v1_reg;
            v2_reg      <= v2_next;
            hraw_reg[2] <= hraw_reg[1];
        end
        if (rdy[3])
        begin
            fine_reg    <= fine_next;
            hraw_reg[3] <= hraw_reg[2];
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = vld_reg[NST-1];
    assign fine     = fine_reg;
    assign adc_h    = hraw_reg[NST-1];

endmodule

// ----- rtl/tph_hum_pipe.sv -----
`timescale 1ns / 1ps
// Eight-stage humidity pipeline: fine temperature and raw humidity to the
// clamped humidity value; also derives the centidegree temperature. Uses tph_pkg.

module tph_hum_pipe
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tph_pkg::cal_t                     cal,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [tph_pkg::FINE_W-1:0] fine,
    input  logic [15:0]                       adc_h,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic signed [tph_pkg::T_W-1:0]    temp_c,
    output logic [tph_pkg::HUM_W-1:0]         hum_q10
);

    localparam int NST = 8;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_in;
    logic [NST:0]   rdy;

    logic signed [tph_pkg::T_W-1:0] tpipe_reg [NST];

    // Stage 0: centidegrees and offset fine temperature.
    logic signed [24:0]              t5;
    logic signed [tph_pkg::T_W-1:0]  t_next;
    logic signed [tph_pkg::X_W-1:0]  x_reg, x_next;
    logic [15:0]                     hraw_reg;
    // Stage 1: the three products of x.
    logic signed [34:0] xh5;
    logic signed [35:0] p_sum;
    logic signed [30:0] xh6;
    logic signed [31:0] xh3;
    logic [31:0]        praw_reg, praw_next;
    logic signed [20:0] q1_reg, q1_next;
    logic signed [20:0] q2_reg, q2_next;
    // Stage 2: rounded p and q1 * q2.
    logic [31:0]        p_add;
    logic signed [41:0] qq;
    logic signed [16:0] p_reg, p_next;
    logic signed [21:0] qa_reg, qa_next;
    // Stage 3: H2 scaling.
    logic signed [22:0] qc;
    logic signed [38:0] qh;
    logic [31:0]        qsum;
    logic signed [16:0] p3_reg;
    logic signed [17:0] qb_reg, qb_next;
    // Stage 4: v = p * q.
    logic signed [34:0] pv;
    logic signed [31:0] v_reg, v_next;
    // Stage 5: square of the upper part of v.
    logic signed [16:0] s1;
    logic signed [33:0] ss;
    logic signed [31:0] v5_reg;
    logic signed [24:0] sq_reg, sq_next;
    // Stage 6: H1 scaling of the square term.
    logic signed [33:0] sh;
    logic signed [31:0] v6_reg;
    logic signed [27:0] shum_reg, shum_next;
    // Stage 7: subtract and clamp.
    logic signed [31:0]             vd;
    logic [tph_pkg::HUM_W-1:0]      hum_reg, hum_next;

    always_comb
    begin
        rdy[NST] = dn_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[NST-2:0], up_valid};

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            vld_next[k] = rdy[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // fine * 5 + 128 stays well inside 25 bits, so no clamp is ever needed.
    assign t5     = (25'(fine) <<< 2) + 25'(fine) + tph_pkg::T_ROUND;
    assign t_next = t5[24:8];
    assign x_next = tph_pkg::X_W'(fine) - tph_pkg::FINE_OFFSET;

    assign xh5       = x_reg * $signed(cal.h5);
    assign p_sum     = $signed({2'b00, hraw_reg, 14'b0}) - $signed({cal.h4, 20'b0}) - xh5;
    assign praw_next = p_sum[31:0];
    assign xh6       = x_reg * $signed(cal.h6);
    assign q1_next   = xh6[30:10];
    assign xh3       = x_reg * $signed({1'b0, cal.h3});
    assign q2_next   = $signed(xh3[31:11]) + tph_pkg::Q2_BIAS;

    assign p_add   = praw_reg + tph_pkg::P_ROUND;
    assign p_next  = p_add[31:15];
    assign qq      = q1_reg * q2_reg;
    assign qa_next = qq[31:10];

    assign qc      = 23'(qa_reg) + tph_pkg::Q_BIAS;
    assign qh      = qc * $signed(cal.h2);
    assign qsum    = qh[31:0] + tph_pkg::Q_ROUND;
    assign qb_next = qsum[31:14];

    assign pv     = p3_reg * qb_reg;
    assign v_next = pv[31:0];

    assign s1      = v_reg[31:15];
    assign ss      = s1 * s1;
    assign sq_next = ss[31:7];

    assign sh        = sq_reg * $signed({1'b0, cal.h1});
    assign shum_next = sh[31:4];

    always_comb
    begin
        vd = v6_reg - 32'(shum_reg);
        if (vd < 0)
        begin
            hum_next = '0;
        end
        else if (vd > tph_pkg::HUM_V_MAX)
        begin
            hum_next = tph_pkg::HUM_Q10_MAX;
        end
        else
        begin
            hum_next = vd[28:12];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            tpipe_reg[0] <= t_next;
            x_reg        <= x_next;
            hraw_reg     <= adc_h;
        end
        if (rdy[1])
        begin
            praw_reg <= praw_next;
            q1_reg   <= q1_next;
            q2_reg   <= q2_next;
        end
        if (rdy[2])
        begin
            p_reg  <= p_next;
            qa_reg <= qa_next;
        end
        if (rdy[3])
        begin
            p3_reg <= p_reg;
            qb_reg <= qb_next;
        end
        if (rdy[4])
        begin
            v_reg <= v_next;
        end
        if (rdy[5])
        begin
            v5_reg <= v_reg;
            sq_reg <= sq_next;
        end
        if (rdy[6])
        begin
            v6_reg   <= v5_reg;
            shum_reg <= shum_next;
        end
        if (rdy[7])
        begin
            hum_reg <= hum_next;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (rdy[k])
            begin
                tpipe_reg[k] <= tpipe_reg[k-1];
            end
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = vld_reg[NST-1];
    assign temp_c   = tpipe_reg[NST-1];
    assign hum_q10  = hum_reg;

endmodule

// ----- rtl/tph_fmt.sv -----
`timescale 1ns / 1ps
// Two-stage output formatter: whole and fraction parts of temperature and humidity.
// The second stage is the output register. Uses tph_pkg.

module tph_fmt
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic signed [tph_pkg::T_W-1:0] temp_c,
    input  logic [tph_pkg::HUM_W-1:0]      hum_q10,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic signed [19:0]             temperature_centi,
    output logic signed [13:0]             temperature_whole,
    output logic [6:0]                     temperature_frac,
    output logic [16:0]                    humidity_q10,
    output logic [6:0]                     humidity_whole,
    output logic [6:0]                     humidity_frac
);

    localparam int NST = 2;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_in;
    logic [NST:0]   rdy;

    // Stage 0: magnitude, quotient by 100 and the humidity split.
    logic [tph_pkg::T_W-1:0]         tabs_next, tabs_reg;
    logic [36:0]                     tm;
    logic [9:0]                      tq_next, tq_reg;
    logic                            tneg_reg;
    logic signed [tph_pkg::T_W-1:0]  t0_reg;
    logic [19:0]                     hm;
    logic [6:0]                      hf_next, hf_reg;
    logic [tph_pkg::HUM_W-1:0]       h0_reg;
    // Stage 1: remainder, signed quotient, output registers.
    logic [tph_pkg::T_W-1:0]         tprod;
    logic [tph_pkg::T_W-1:0]         trem;
    logic [13:0]                     tq_ext;
    logic signed [13:0]              whole_next, whole_reg;
    logic [6:0]                      frac_next, frac_reg;
    logic signed [tph_pkg::T_W-1:0]  t1_reg;
    logic [tph_pkg::HUM_W-1:0]       h1_reg;
    logic [6:0]                      hf1_reg;

    always_comb
    begin
        rdy[NST] = dn_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[NST-2:0], up_valid};

    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            vld_next[k] = rdy[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // The reciprocal is exact for every magnitude the temperature path can produce.
    assign tabs_next = temp_c[tph_pkg::T_W-1] ? tph_pkg::T_W'(-temp_c)
                                              : tph_pkg::T_W'(temp_c);
    assign tm        = tabs_next * tph_pkg::DIV100_RECIP;
    assign tq_next   = tm[35:26];
    assign hm        = hum_q10[9:0] * tph_pkg::DIV11_RECIP;
    assign hf_next   = hm[19:13];

    assign tprod      = tph_pkg::T_W'(tq_reg) * tph_pkg::CENTI_SCALE;
    assign trem       = tabs_reg - tprod;
    assign frac_next  = trem[6:0];
    assign tq_ext     = {4'b0000, tq_reg};
    assign whole_next = tneg_reg ? (14'd0 - tq_ext) : tq_ext;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            tabs_reg <= tabs_next;
            tq_reg   <= tq_next;
            tneg_reg <= temp_c[tph_pkg::T_W-1];
            t0_reg   <= temp_c;
            hf_reg   <= hf_next;
            h0_reg   <= hum_q10;
        end
        if (rdy[1])
        begin
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
            t1_reg    <= t0_reg;
            h1_reg    <= h0_reg;
            hf1_reg   <= hf_reg;
        end
    end

    assign up_ready          = rdy[0];
    assign dn_valid          = vld_reg[NST-1];
    assign temperature_centi = 20'(t1_reg);
    assign temperature_whole = whole_reg;
    assign temperature_frac  = frac_reg;
    assign humidity_q10      = h1_reg;
    assign humidity_whole    = h1_reg[16:10];
    assign humidity_frac     = hf1_reg;

endmodule

// ----- rtl/temp_humidity_compensation_core.sv -----
`timescale 1ns / 1ps
// Top level of the temperature and humidity compensation core: calibration
// registers and the three pipeline sections. Depends on tph_pkg and its submodules.

// The core takes one raw temperature and humidity reading per transaction and
// returns the compensated temperature in centidegrees and the relative humidity
// in percent times 1024, each also split into whole and fraction parts. It is
// fully pipelined: a new reading can be accepted every clock cycle unless the
// pipeline is full and the result side stalls. It has 14 register stages
// (4 temperature, 8 humidity, 2 formatting), a number set by the chain of
// dependent multiplications with no two of them in one register stage. When the
// result side stalls, each stage holds only if the stage after it is full, so
// bubbles are squeezed out and readings keep entering until the pipeline is full.
// Calibration registers reset to zero, take a write every cycle, and should be
// written only while no reading is in flight; writes to indexes beyond the eighth
// register are ignored.

module temp_humidity_compensation_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tph_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [19:0]                      raw_temperature,
    input  logic [15:0]                      raw_humidity,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic signed [19:0]               temperature_centi,
    output logic signed [13:0]               temperature_whole,
    output logic [6:0]                       temperature_frac,
    output logic [16:0]                      humidity_q10,
    output logic [6:0]                       humidity_whole,
    output logic [6:0]                       humidity_frac
);

    tph_pkg::cal_t cal_reg, cal_next;

    logic                              tp_valid, tp_ready;
    logic signed [tph_pkg::FINE_W-1:0] fine;
    logic [15:0]                       adc_h;
    logic                              hp_valid, hp_ready;
    logic signed [tph_pkg::T_W-1:0]    temp_c;
    logic [tph_pkg::HUM_W-1:0]         hum_q10;
    logic                              fmt_ready;
    logic signed [20:0]                chk_centi;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tph_pkg::REG_CAL_T1:  cal_next.t1 = cfg_data[15:0];
                tph_pkg::REG_CAL_T2:  cal_next.t2 = cfg_data[15:0];
                tph_pkg::REG_CAL_T3:  cal_next.t3 = cfg_data[15:0];
                tph_pkg::REG_CAL_H1:  cal_next.h1 = cfg_data[7:0];
                tph_pkg::REG_CAL_H2:  cal_next.h2 = cfg_data[15:0];
                tph_pkg::REG_CAL_H3:  cal_next.h3 = cfg_data[7:0];
                tph_pkg::REG_CAL_H45:
                begin
                    cal_next.h4 = cfg_data[11:0];
                    cal_next.h5 = cfg_data[23:12];
                end
                tph_pkg::REG_CAL_H6:  cal_next.h6 = cfg_data[7:0];
                default:              cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    tph_temp_pipe u_temp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal      (cal_reg),
        .up_valid (sample_valid),
        .up_ready (tp_ready),
        .raw_t    (raw_temperature),
        .raw_h    (raw_humidity),
        .dn_valid (tp_valid),
        .dn_ready (hp_ready),
        .fine     (fine),
        .adc_h    (adc_h)
    );

    tph_hum_pipe u_hum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal      (cal_reg),
        .up_valid (tp_valid),
        .up_ready (hp_ready),
        .fine     (fine),
        .adc_h    (adc_h),
        .dn_valid (hp_valid),
        .dn_ready (fmt_ready),
        .temp_c   (temp_c),
        .hum_q10  (hum_q10)
    );

    tph_fmt u_fmt
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .up_valid          (hp_valid),
        .up_ready          (fmt_ready),
        .temp_c            (temp_c),
        .hum_q10           (hum_q10),
        .dn_valid          (result_valid),
        .dn_ready          (!result_stall),
        .temperature_centi (temperature_centi),
        .temperature_whole (temperature_whole),
        .temperature_frac  (temperature_frac),
        .humidity_q10      (humidity_q10),
        .humidity_whole    (humidity_whole),
        .humidity_frac     (humidity_frac)
    );

    assign sample_stall = !tp_ready;

    // Rebuild the centidegree value from its split parts for checking.
    assign chk_centi = 21'(temperature_whole) * 21'sd100
                     + (temperature_centi[19] ? (21'd0 - 21'(temperature_frac))
                                              : 21'(temperature_frac));

    a_hum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (humidity_q10 <= tph_pkg::HUM_Q10_MAX))
        else $error("humidity result exceeds the clamp limit");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((temperature_frac < 7'd100) && (humidity_frac <= 7'd93)))
        else $error("fraction part out of range");

    a_temp_split: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (chk_centi == 21'(temperature_centi)))
        else $error("temperature whole and fraction parts disagree with centidegrees");

endmodule
